### rtl/stcs_pkg.sv
// Shared types and constants for the structure tree builder.
package stcs_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int NUM_CLASSES  = 1024;
    localparam int EAW          = $clog2(MAX_ELEMENTS);
    localparam int ECW          = $clog2(MAX_ELEMENTS + 1);
    localparam int CAW          = $clog2(NUM_CLASSES);
    localparam int CLW          = 10;

    localparam logic [ECW-1:0] NO_VERTEX = ECW'(MAX_ELEMENTS);

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROCESS = 1'b1;

    typedef struct packed {
        logic           command;
        logic [CLW-1:0] class_id;
    } t_in_word;

    typedef struct packed {
        logic        vertex_added;
        logic [9:0]  vertex_index;
        logic [10:0] parent_index;
        logic [9:0]  vertex_class;
        logic        done_res;
    } t_out_word;

    typedef struct packed {
        logic [CLW-1:0] cls;
        logic [EAW-1:0] occ;
    } t_elem_entry;

    typedef struct packed {
        logic           flag;
        logic [ECW-1:0] count;
    } t_cls_entry;

    typedef struct packed {
        logic           we;
        logic [EAW-1:0] waddr;
        t_elem_entry    wdata;
        logic           re;
        logic [EAW-1:0] raddr;
    } t_elem_req;

    typedef struct packed {
        logic           we;
        logic [CAW-1:0] waddr;
        t_cls_entry     wdata;
        logic           re;
        logic [CAW-1:0] raddr;
    } t_cls_req;

    typedef struct packed {
        logic           we;
        logic [EAW-1:0] waddr;
        logic [ECW-1:0] wdata;
        logic           re;
        logic [EAW-1:0] raddr;
    } t_vtx_req;

endpackage

### rtl/stcs_elem_mem.sv
// Element memory: class id and occurrence index per loaded element.
module stcs_elem_mem (
    input  logic                  i_clk,
    input  stcs_pkg::t_elem_req   i_req,
    output stcs_pkg::t_elem_entry o_rdata
);

    stcs_pkg::t_elem_entry mem [stcs_pkg::MAX_ELEMENTS];
    stcs_pkg::t_elem_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/stcs_class_mem.sv
// Class memory: occurrence count and nesting flag per class, cleared after reset.
module stcs_class_mem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stcs_pkg::t_cls_req   i_req,
    output stcs_pkg::t_cls_entry o_rdata,
    output logic                 o_busy
);

    stcs_pkg::t_cls_entry        mem [stcs_pkg::NUM_CLASSES];
    stcs_pkg::t_cls_entry        r_rdata;
    logic                        r_busy;
    logic [stcs_pkg::CAW-1:0]    r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == stcs_pkg::CAW'(stcs_pkg::NUM_CLASSES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_idx] <= '0;
        end else if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

### rtl/stcs_vertex_mem.sv
// Vertex memory: parent index per created vertex.
module stcs_vertex_mem (
    input  logic                     i_clk,
    input  stcs_pkg::t_vtx_req       i_req,
    output logic [stcs_pkg::ECW-1:0] o_rdata
);

    logic [stcs_pkg::ECW-1:0] mem [stcs_pkg::MAX_ELEMENTS];
    logic [stcs_pkg::ECW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/structure_tree_from_class_sequence.sv
// Top level: load/process sequencer around the element, class and vertex memories.
//
// A load word reads the class memory in S_IDLE and writes back in S_LOAD before the next
// word can be taken; a process word passes through S_P1, S_P2, S_P3 and S_EMIT (straight
// to S_EMIT when every loaded element is already processed), set by three dependent reads
// (the element memory, then the class memory for the element's class, then the class
// memory for the previous class) followed by the write-back and the result register.
// One word is worked on at a time; a finished result waits in the output register
// while the next word is accepted, and a new result that finds that register still
// stalled holds the input off until it drains. After reset a clearing pass over every
// class entry zeroes the class memory, and no word is accepted until it ends.
module structure_tree_from_class_sequence (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stcs_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stcs_pkg::t_out_word o_out_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_P1,
        S_P2,
        S_P3,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    logic [stcs_pkg::ECW-1:0] r_load_count, n_load_count;
    logic [stcs_pkg::ECW-1:0] r_pp, n_pp;
    logic [stcs_pkg::ECW-1:0] r_cv, n_cv;
    logic [stcs_pkg::ECW-1:0] r_vc, n_vc;
    logic [stcs_pkg::CLW-1:0] r_prev_cls, n_prev_cls;
    logic [stcs_pkg::EAW-1:0] r_prev_occ, n_prev_occ;
    logic [stcs_pkg::CLW-1:0] r_lvc, n_lvc;
    logic                     r_out_valid, n_out_valid;

    logic [stcs_pkg::CLW-1:0] r_cls, n_cls;
    logic [stcs_pkg::EAW-1:0] r_pos, n_pos;
    logic [stcs_pkg::ECW-1:0] r_n, n_n;
    logic                     r_flag, n_flag;
    logic [stcs_pkg::ECW-1:0] r_par, n_par;
    logic                     r_load_ok, n_load_ok;
    stcs_pkg::t_out_word      r_res, n_res;
    stcs_pkg::t_out_word      r_out_word, n_out_word;

    stcs_pkg::t_elem_req      elem_req;
    stcs_pkg::t_elem_entry    elem_rdata;
    stcs_pkg::t_cls_req       cls_req;
    stcs_pkg::t_cls_entry     cls_rdata;
    logic                     cls_busy;
    stcs_pkg::t_vtx_req       vtx_req;
    logic [stcs_pkg::ECW-1:0] vtx_rdata;

    logic                     in_acc;

    stcs_elem_mem u_elem (
        .i_clk   (i_clk),
        .i_req   (elem_req),
        .o_rdata (elem_rdata)
    );

    stcs_class_mem u_class (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cls_req),
        .o_rdata (cls_rdata),
        .o_busy  (cls_busy)
    );

    stcs_vertex_mem u_vertex (
        .i_clk   (i_clk),
        .i_req   (vtx_req),
        .o_rdata (vtx_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE) || cls_busy;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        logic                     do_add;
        logic [stcs_pkg::ECW-1:0] add_par;

        n_state      = r_state;
        n_load_count = r_load_count;
        n_pp         = r_pp;
        n_cv         = r_cv;
        n_vc         = r_vc;
        n_prev_cls   = r_prev_cls;
        n_prev_occ   = r_prev_occ;
        n_lvc        = r_lvc;
        n_out_valid  = r_out_valid;
        n_cls        = r_cls;
        n_pos        = r_pos;
        n_n          = r_n;
        n_flag       = r_flag;
        n_par        = r_par;
        n_load_ok    = r_load_ok;
        n_res        = r_res;
        n_out_word   = r_out_word;
        elem_req     = '0;
        cls_req      = '0;
        vtx_req      = '0;
        do_add       = 1'b0;
        add_par      = stcs_pkg::NO_VERTEX;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.command == stcs_pkg::CMD_PROCESS) begin
                        if (r_pp >= r_load_count) begin
                            n_res          = '0;
                            n_res.done_res = 1'b1;
                            n_state        = S_EMIT;
                        end else begin
                            elem_req.re    = 1'b1;
                            elem_req.raddr = r_pp[stcs_pkg::EAW-1:0];
                            n_state        = S_P1;
                        end
                    end else begin
                        n_cls         = i_in_word.class_id;
                        n_load_ok     = r_load_count < stcs_pkg::ECW'(stcs_pkg::MAX_ELEMENTS);
                        cls_req.re    = 1'b1;
                        cls_req.raddr = stcs_pkg::CAW'(i_in_word.class_id);
                        n_state       = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (r_load_ok) begin
                    elem_req.we        = 1'b1;
                    elem_req.waddr     = r_load_count[stcs_pkg::EAW-1:0];
                    elem_req.wdata.cls = r_cls;
                    elem_req.wdata.occ = cls_rdata.count[stcs_pkg::EAW-1:0];
                    cls_req.we         = 1'b1;
                    cls_req.waddr      = stcs_pkg::CAW'(r_cls);
                    cls_req.wdata.flag = cls_rdata.flag;
                    if (cls_rdata.count < stcs_pkg::ECW'(stcs_pkg::MAX_ELEMENTS)) begin
                        cls_req.wdata.count = cls_rdata.count + 1'b1;
                    end else begin
                        cls_req.wdata.count = cls_rdata.count;
                    end
                    n_load_count = r_load_count + 1'b1;
                end
                n_state = S_IDLE;
            end
            S_P1: begin
                n_cls         = elem_rdata.cls;
                n_pos         = elem_rdata.occ;
                cls_req.re    = 1'b1;
                cls_req.raddr = stcs_pkg::CAW'(elem_rdata.cls);
                vtx_req.re    = 1'b1;
                vtx_req.raddr = r_cv[stcs_pkg::EAW-1:0];
                n_pp          = r_pp + 1'b1;
                n_state       = S_P2;
            end
            S_P2: begin
                n_n    = cls_rdata.count;
                n_flag = cls_rdata.flag;
                if (r_cv != stcs_pkg::NO_VERTEX && r_cv < r_vc) begin
                    n_par = vtx_rdata;
                end else begin
                    n_par = stcs_pkg::NO_VERTEX;
                end
                cls_req.re    = 1'b1;
                cls_req.raddr = stcs_pkg::CAW'(r_prev_cls);
                n_state       = S_P3;
            end
            S_P3: begin
                n_res = '0;
                if (r_n != stcs_pkg::ECW'(1)) begin
                    if (r_vc == '0) begin
                        do_add  = 1'b1;
                        add_par = stcs_pkg::NO_VERTEX;
                    end else if (r_flag) begin
                        n_cv                = r_par;
                        cls_req.we          = 1'b1;
                        cls_req.waddr       = stcs_pkg::CAW'(r_cls);
                        cls_req.wdata.flag  = 1'b0;
                        cls_req.wdata.count = r_n;
                    end else if (r_prev_cls == r_cls) begin
                        if ((stcs_pkg::ECW'(r_pos) + 1'b1 < r_n) || (r_lvc != r_cls)) begin
                            do_add  = 1'b1;
                            add_par = r_par;
                        end
                    end else begin
                        if (stcs_pkg::ECW'(r_prev_occ) + 1'b1 < cls_rdata.count) begin
                            cls_req.we          = 1'b1;
                            cls_req.waddr       = stcs_pkg::CAW'(r_prev_cls);
                            cls_req.wdata.flag  = 1'b1;
                            cls_req.wdata.count = cls_rdata.count;
                            do_add              = 1'b1;
                            add_par             = r_cv;
                        end else if (stcs_pkg::ECW'(r_pos) + 1'b1 < r_n) begin
                            do_add  = 1'b1;
                            add_par = r_par;
                        end else begin
                            n_cv = r_par;
                        end
                    end
                    n_prev_cls = r_cls;
                    n_prev_occ = r_pos;
                end
                if (do_add && r_vc < stcs_pkg::ECW'(stcs_pkg::MAX_ELEMENTS)) begin
                    vtx_req.we         = 1'b1;
                    vtx_req.waddr      = r_vc[stcs_pkg::EAW-1:0];
                    vtx_req.wdata      = add_par;
                    n_res.vertex_added = 1'b1;
                    n_res.vertex_index = 10'(r_vc);
                    n_res.parent_index = 11'(add_par);
                    n_res.vertex_class = 10'(r_cls);
                    n_cv               = r_vc;
                    n_lvc              = r_cls;
                    n_vc               = r_vc + 1'b1;
                end
                n_res.done_res = r_pp >= r_load_count;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cls      <= n_cls;
        r_pos      <= n_pos;
        r_n        <= n_n;
        r_flag     <= n_flag;
        r_par      <= n_par;
        r_load_ok  <= n_load_ok;
        r_res      <= n_res;
        r_out_word <= n_out_word;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_load_count <= '0;
            r_pp         <= '0;
            r_cv         <= '0;
            r_vc         <= '0;
            r_prev_cls   <= '0;
            r_prev_occ   <= '0;
            r_lvc        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_load_count <= n_load_count;
            r_pp         <= n_pp;
            r_cv         <= n_cv;
            r_vc         <= n_vc;
            r_prev_cls   <= n_prev_cls;
            r_prev_occ   <= n_prev_occ;
            r_lvc        <= n_lvc;
            r_out_valid  <= n_out_valid;
        end
    end

endmodule

### rtl/stcs_checker.sv
// Port-level assertions for the structure tree builder, bound to the top level.
module stcs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input stcs_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input stcs_pkg::t_out_word o_out_word
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("stalled input word changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("word accepted on back-to-back cycles");

    a_no_vertex_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.vertex_added |->
            o_out_word.vertex_index == '0 && o_out_word.parent_index == '0
            && o_out_word.vertex_class == '0)
        else $error("vertex fields set without a vertex");

    a_parent_older: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.vertex_added |->
            o_out_word.parent_index == stcs_pkg::NO_VERTEX
            || o_out_word.parent_index < {1'b0, o_out_word.vertex_index})
        else $error("parent is not an earlier vertex");

endmodule

bind structure_tree_from_class_sequence stcs_checker u_stcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

### verif/tb_structure_tree_from_class_sequence.sv
// Self-checking testbench for the structure tree builder: load/process words in, vertex words out.
`timescale 1ns / 1ps
module tb_structure_tree_from_class_sequence;

    localparam int QUIET_LIMIT = 4000;
    localparam int PRINT_LIMIT = 100;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    stcs_pkg::t_in_word  i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    stcs_pkg::t_out_word o_out_word;

    // tree state as the block should hold it
    bit [9:0]  elem_cls [stcs_pkg::MAX_ELEMENTS];
    bit [9:0]  elem_occ [stcs_pkg::MAX_ELEMENTS];
    bit [10:0] cls_cnt [stcs_pkg::NUM_CLASSES];
    bit        nest_flag [stcs_pkg::NUM_CLASSES];
    bit [10:0] vtx_parent [stcs_pkg::MAX_ELEMENTS];
    bit [10:0] cur_vtx;
    bit [10:0] n_vtx;
    bit [10:0] proc_ptr;
    bit [10:0] n_loaded;
    bit [9:0]  prev_cls;
    bit [9:0]  prev_occ;
    bit [9:0]  last_vcls;

    stcs_pkg::t_out_word expected_words [$];
    int        n_errors = 0;
    int        n_items = 0;
    bit        idle_on = 1'b1;
    int        stall_left = 0;
    int        quiet_cycles = 0;

    structure_tree_from_class_sequence i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit [10:0] parent_of_vtx(input bit [10:0] v);
        if (v != stcs_pkg::NO_VERTEX && v < n_vtx) begin
            return vtx_parent[v[9:0]];
        end
        return stcs_pkg::NO_VERTEX;
    endfunction

    function automatic void grow_vertex(input bit [10:0] par, input bit [9:0] c,
                                        inout stcs_pkg::t_out_word r);
        if (n_vtx >= stcs_pkg::MAX_ELEMENTS) begin
            return;
        end
        vtx_parent[n_vtx[9:0]] = par;
        r.vertex_added = 1'b1;
        r.vertex_index = n_vtx[9:0];
        r.parent_index = par;
        r.vertex_class = c;
        cur_vtx = n_vtx;
        last_vcls = c;
        n_vtx++;
    endfunction

    function automatic void grow_tree(input stcs_pkg::t_in_word w);
        stcs_pkg::t_out_word r;
        bit [9:0]  c;
        bit [9:0]  pos;
        bit [10:0] n;
        r = '0;
        if (w.command == stcs_pkg::CMD_LOAD) begin
            if (n_loaded < stcs_pkg::MAX_ELEMENTS) begin
                elem_cls[n_loaded[9:0]] = w.class_id;
                elem_occ[n_loaded[9:0]] = cls_cnt[w.class_id][9:0];
                if (cls_cnt[w.class_id] < stcs_pkg::MAX_ELEMENTS) begin
                    cls_cnt[w.class_id]++;
                end
                n_loaded++;
            end
            return;
        end
        if (proc_ptr >= n_loaded) begin
            r.done_res = 1'b1;
            expected_words.insert(expected_words.size(), r);
            return;
        end
        c = elem_cls[proc_ptr[9:0]];
        pos = elem_occ[proc_ptr[9:0]];
        n = cls_cnt[c];
        proc_ptr++;
        if (n != 1) begin
            if (n_vtx == 0) begin
                grow_vertex(stcs_pkg::NO_VERTEX, c, r);
                cur_vtx = '0;
            end else if (nest_flag[c]) begin
                cur_vtx = parent_of_vtx(cur_vtx);
                nest_flag[c] = 1'b0;
            end else if (prev_cls == c) begin
                if (pos + 1 < n || last_vcls != c) begin
                    grow_vertex(parent_of_vtx(cur_vtx), c, r);
                end
            end else if (prev_occ + 1 < cls_cnt[prev_cls]) begin
                nest_flag[prev_cls] = 1'b1;
                grow_vertex(cur_vtx, c, r);
            end else if (pos + 1 < n) begin
                grow_vertex(parent_of_vtx(cur_vtx), c, r);
            end else begin
                cur_vtx = parent_of_vtx(cur_vtx);
            end
            prev_cls = c;
            prev_occ = pos;
        end
        r.done_res = (proc_ptr >= n_loaded);
        expected_words.insert(expected_words.size(), r);
    endfunction

    // nested region: open class, optional inner regions, close class
    function automatic void nest_region(ref bit [9:0] seq [$], input int depth);
        bit [9:0] c;
        int       reps;
        c = 10'($urandom_range(0, 1023));
        reps = $urandom_range(1, 3);
        seq.insert(seq.size(), c);
        for (int i = 0; i < reps; i++) begin
            if (depth > 0 && $urandom_range(0, 1) == 1) begin
                nest_region(seq, depth - 1);
            end
            seq.insert(seq.size(), c);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < PRINT_LIMIT) begin
            $display("%0t %s: got %0d, expected %0d", $time, what, got, want);
        end
        n_errors++;
    endtask

    task automatic check_word(input stcs_pkg::t_out_word got);
        stcs_pkg::t_out_word want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
            return;
        end
        want = expected_words.pop_front();
        if (got.vertex_added !== want.vertex_added) begin
            report_mismatch("vertex_added", int'(got.vertex_added), int'(want.vertex_added));
        end
        if (got.vertex_index !== want.vertex_index) begin
            report_mismatch("vertex_index", int'(got.vertex_index), int'(want.vertex_index));
        end
        if (got.parent_index !== want.parent_index) begin
            report_mismatch("parent_index", int'(got.parent_index), int'(want.parent_index));
        end
        if (got.vertex_class !== want.vertex_class) begin
            report_mismatch("vertex_class", int'(got.vertex_class), int'(want.vertex_class));
        end
        if (got.done_res !== want.done_res) begin
            report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
        end
    endtask

    task automatic send_word(input logic cmd, input bit [9:0] cls);
        stcs_pkg::t_in_word w;
        w.command = cmd;
        w.class_id = cls;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        grow_tree(w);
        n_items++;
    endtask

    task automatic process_next();
        send_word(stcs_pkg::CMD_PROCESS, 10'($urandom_range(0, 1023)));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_process_when_empty();
        process_next();
        wait_drained();
    endtask

    // root, nested child, exit to parent, tandem sibling, class-change sibling and exit
    task automatic test_region_shapes();
        bit [9:0] shape [$] = '{10'd1023, 10'd5, 10'd9, 10'd9, 10'd5, 10'd5,
                                10'd0, 10'd0, 10'd3, 10'd7, 10'd3, 10'd7};
        foreach (shape[i]) begin
            send_word(stcs_pkg::CMD_LOAD, shape[i]);
        end
        repeat (shape.size() + 1) process_next();
        wait_drained();
    endtask

    task automatic test_random_sequences();
        bit [9:0]  seq [$];
        bit [10:0] lag_floor;
        bit        loose;
        int        start_items;
        start_items = n_items;
        while (n_items - start_items < 300 && n_loaded < 150) begin
            seq.delete();
            idle_on = ($urandom_range(0, 3) != 0);
            loose = ($urandom_range(0, 4) == 0);
            if (loose) begin
                repeat ($urandom_range(2, 8)) seq.insert(seq.size(), 10'($urandom_range(0, 7)));
            end else begin
                nest_region(seq, $urandom_range(0, 3));
                if ($urandom_range(0, 2) == 0) begin
                    seq.insert($urandom_range(0, seq.size()), 10'($urandom_range(0, 1023)));
                end
            end
            lag_floor = n_loaded;
            foreach (seq[i]) begin
                send_word(stcs_pkg::CMD_LOAD, seq[i]);
                if ($urandom_range(0, 1) == 1 && (loose || proc_ptr < lag_floor)) begin
                    process_next();
                end
            end
        end
        while (proc_ptr < n_loaded) process_next();
        wait_drained();
    endtask

    task automatic test_store_full();
        bit [9:0] seq [$];
        idle_on = 1'b0;
        while (n_loaded < stcs_pkg::MAX_ELEMENTS) begin
            seq.delete();
            nest_region(seq, $urandom_range(0, 3));
            foreach (seq[i]) begin
                send_word(stcs_pkg::CMD_LOAD, seq[i]);
            end
        end
        repeat (4) send_word(stcs_pkg::CMD_LOAD, 10'($urandom_range(0, 1023)));
        repeat (16) process_next();
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_word(o_out_word);
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 12);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("structure_tree_from_class_sequence: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_process_when_empty();
        test_region_shapes();
        test_random_sequences();
        test_store_full();
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("structure_tree_from_class_sequence: match");
        end else begin
            $display("structure_tree_from_class_sequence: mismatch");
        end
        $finish;
    end

endmodule
